// File: rtl/ps2_keyboard_scancode_device_macros.svh
// Assertion macros used by the keyboard device RTL.
`ifndef PS2_KEYBOARD_SCANCODE_DEVICE_MACROS_SVH
`define PS2_KEYBOARD_SCANCODE_DEVICE_MACROS_SVH
`ifndef SYNTHESIS
`define KB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define KB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define KB_ASSERT(label, clk, rst_n, prop, msg)
`define KB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/ps2kb_pkg.sv
`timescale 1ns / 1ps

package ps2kb_pkg;

    localparam int QUEUE_BYTES = 8;
    localparam int CODE_BYTES  = 4;
    localparam int WORD_BYTES  = 8;

    localparam int QUEUE_W  = 8 * QUEUE_BYTES;
    localparam int WORD_W   = 8 * WORD_BYTES;
    localparam int CODE_W   = 8 * CODE_BYTES;
    localparam int POS_W    = $clog2(QUEUE_BYTES + 1);

    localparam int ACTION_W   = 3;
    localparam int KEY_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int ELAPSED_W  = 24;
    localparam int LEFT_W     = 30;
    localparam int PERIOD_W   = 28;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [KEY_W-1:0] CODE_MASK = KEY_W'((64'd1 << CODE_W) - 64'd1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRESS       = 3'd0,
        ACT_RELEASE     = 3'd1,
        ACT_HOST_WRITE  = 3'd2,
        ACT_HOST_READ   = 3'd3,
        ACT_TICK        = 3'd4,
        ACT_RELEASE_ALL = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        PEND_NONE = 4'b0001,
        PEND_LEDS = 4'b0010,
        PEND_SET  = 4'b0100,
        PEND_RATE = 4'b1000
    } pend_t;

    localparam logic [0:0] REG_SCANCODE_SET = 1'b0;

    localparam logic [BYTE_W-1:0] CMD_SET_LEDS   = 8'hED;
    localparam logic [BYTE_W-1:0] CMD_ECHO       = 8'hEE;
    localparam logic [BYTE_W-1:0] CMD_CODE_SET   = 8'hF0;
    localparam logic [BYTE_W-1:0] CMD_READ_ID    = 8'hF2;
    localparam logic [BYTE_W-1:0] CMD_TYPEMATIC  = 8'hF3;
    localparam logic [BYTE_W-1:0] CMD_ENABLE     = 8'hF4;
    localparam logic [BYTE_W-1:0] CMD_DISABLE    = 8'hF5;
    localparam logic [BYTE_W-1:0] CMD_ACK_LOW    = 8'hF6;
    localparam logic [BYTE_W-1:0] CMD_RESEND     = 8'hFE;

    localparam logic [BYTE_W-1:0] BREAK_PREFIX = 8'hF0;
    localparam logic [BYTE_W-1:0] XT_BREAK_BIT = 8'h80;

    localparam logic [WORD_W-1:0] REPLY_ACK      = 64'hFA;
    localparam logic [WORD_W-1:0] REPLY_ECHO     = 64'hEE;
    localparam logic [WORD_W-1:0] REPLY_ID       = 64'h83ABFA;
    localparam logic [WORD_W-1:0] REPLY_SET_QRY  = 64'h02FA;

    localparam logic [LEFT_W-1:0]   DELAY_STEP_NS  = 30'd250000000;
    localparam logic [LEFT_W-1:0]   DELAY_RESET_NS = 30'd500000000;
    localparam logic [PERIOD_W-1:0] PERIOD_UNIT_NS = 28'd1000000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET_NS = 28'd50000000;
    localparam logic [7:0]          PERIOD_BASE    = 8'd33;
    localparam logic [7:0]          PERIOD_STEP    = 8'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [KEY_W-1:0]     key_code;
        logic [BYTE_W-1:0]    host_byte;
        logic [ELAPSED_W-1:0] elapsed_ns;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              irq;
        logic              repeat_fired;
    } result_t;

endpackage

// File: rtl/ps2kb_if.sv
`timescale 1ns / 1ps

interface ps2kb_req_if;
    logic                                valid;
    logic                                ready;
    logic [ps2kb_pkg::ACTION_W-1:0]      action;
    logic [ps2kb_pkg::KEY_W-1:0]         key_code;
    logic [ps2kb_pkg::BYTE_W-1:0]        host_byte;
    logic [ps2kb_pkg::ELAPSED_W-1:0]     elapsed_ns;

    modport source (output valid, action, key_code, host_byte, elapsed_ns, input ready);
    modport sink (input valid, action, key_code, host_byte, elapsed_ns, output ready);
endinterface

interface ps2kb_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [ps2kb_pkg::BYTE_W-1:0]        read_byte;
    logic                                read_valid;
    logic                                irq;
    logic                                repeat_fired;

    modport source (output valid, read_byte, read_valid, irq, repeat_fired, input ready);
    modport sink (input valid, read_byte, read_valid, irq, repeat_fired, output ready);
endinterface

// File: rtl/ps2kb_core.sv
`timescale 1ns / 1ps

module ps2kb_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ps2kb_pkg::item_t    item,
    input  logic                scancode_set,
    output ps2kb_pkg::result_t  result
);
    import ps2kb_pkg::*;

    logic [QUEUE_W-1:0]   queue_reg, queue_next;
    logic [BYTE_W-1:0]    last_byte_reg, last_byte_next;
    pend_t                pend_reg, pend_next;
    logic                 reporting_off_reg, reporting_off_next;
    logic [KEY_W-1:0]     repeat_key_reg, repeat_key_next;
    logic [LEFT_W-1:0]    repeat_left_reg, repeat_left_next;
    logic [LEFT_W-1:0]    repeat_delay_reg, repeat_delay_next;
    logic [PERIOD_W-1:0]  repeat_period_reg, repeat_period_next;

    logic [KEY_W-1:0]     key_m;
    logic [7:0]           period_mult;

    // Bytes are appended just above the highest nonzero byte; overflow is lost.
    function automatic logic [QUEUE_W-1:0] queue_append(
        input logic [QUEUE_W-1:0] q,
        input logic [WORD_W-1:0]  code
    );
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] wide;
        pos = '0;
        for (int i = 0; i < QUEUE_BYTES; i++) begin
            if (q[8*i +: 8] != 8'd0)
            begin
                pos = POS_W'(i + 1);
            end
        end
        wide = WORD_W'(q);
        if (pos < POS_W'(QUEUE_BYTES))
        begin
            wide = wide | (code << {pos, 3'b000});
        end
        return wide[QUEUE_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] break_code(
        input logic [KEY_W-1:0] key,
        input logic             xt
    );
        logic [WORD_W-1:0]  res;
        logic [3:0]         n;
        logic [3:0]         len;
        logic [BYTE_W-1:0]  b;
        res = '0;
        n   = '0;
        len = '0;
        for (int i = 0; i < CODE_BYTES; i++) begin
            if (key[8*i +: 8] != 8'd0)
            begin
                len = 4'(i + 1);
            end
        end
        for (int i = 0; i < CODE_BYTES; i++) begin
            b = key[8*i +: 8];
            if (4'(i) < len)
            begin
                if (xt)
                begin
                    res = res | (WORD_W'(b | XT_BREAK_BIT) << {n, 3'b000});
                    n   = n + 4'd1;
                end
                else
                begin
                    if (!b[7])
                    begin
                        res = res | (WORD_W'(BREAK_PREFIX) << {n, 3'b000});
                        n   = n + 4'd1;
                    end
                    if (b != 8'd0)
                    begin
                        res = res | (WORD_W'(b) << {n, 3'b000});
                        n   = n + 4'd1;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic logic [LEFT_W-1:0] typematic_delay(input logic [1:0] sel);
        logic [LEFT_W-1:0] d;
        case (sel)
            2'd0:    d = DELAY_STEP_NS;
            2'd1:    d = LEFT_W'(DELAY_STEP_NS * 2);
            2'd2:    d = LEFT_W'(DELAY_STEP_NS * 3);
            default: d = LEFT_W'(DELAY_STEP_NS * 4);
        endcase
        return d;
    endfunction

    assign key_m       = item.key_code & CODE_MASK;
    assign period_mult = PERIOD_BASE + PERIOD_STEP * {3'b000, item.host_byte[4:0]};

    always_comb
    begin
        queue_next         = queue_reg;
        last_byte_next     = last_byte_reg;
        pend_next          = pend_reg;
        reporting_off_next = reporting_off_reg;
        repeat_key_next    = repeat_key_reg;
        repeat_left_next   = repeat_left_reg;
        repeat_delay_next  = repeat_delay_reg;
        repeat_period_next = repeat_period_reg;
        result             = '0;

        case (action_t'(item.action))
            ACT_PRESS:
            begin
                if (!reporting_off_reg)
                begin
                    queue_next       = queue_append(queue_reg, WORD_W'(key_m));
                    repeat_key_next  = key_m;
                    repeat_left_next = repeat_delay_reg;
                    result.irq       = 1'b1;
                end
            end
            ACT_RELEASE:
            begin
                if (!reporting_off_reg)
                begin
                    queue_next       = queue_append(queue_reg, break_code(key_m, scancode_set));
                    repeat_left_next = '0;
                    result.irq       = 1'b1;
                end
            end
            ACT_HOST_WRITE:
            begin
                if (pend_reg != PEND_NONE)
                begin
                    pend_next  = PEND_NONE;
                    result.irq = 1'b1;
                    if (pend_reg == PEND_SET && item.host_byte == 8'd0)
                    begin
                        queue_next = REPLY_SET_QRY[QUEUE_W-1:0];
                    end
                    else
                    begin
                        if (pend_reg == PEND_RATE)
                        begin
                            repeat_delay_next  = typematic_delay(item.host_byte[6:5]);
                            repeat_period_next = PERIOD_W'(period_mult) * PERIOD_UNIT_NS;
                        end
                        queue_next = REPLY_ACK[QUEUE_W-1:0];
                    end
                end
                else
                begin
                    result.irq = 1'b1;
                    case (item.host_byte)
                        CMD_SET_LEDS:
                        begin
                            queue_next = REPLY_ACK[QUEUE_W-1:0];
                            pend_next  = PEND_LEDS;
                        end
                        CMD_ECHO:
                        begin
                            queue_next = REPLY_ECHO[QUEUE_W-1:0];
                        end
                        CMD_CODE_SET:
                        begin
                            queue_next = REPLY_ACK[QUEUE_W-1:0];
                            pend_next  = PEND_SET;
                        end
                        CMD_READ_ID:
                        begin
                            queue_next = REPLY_ID[QUEUE_W-1:0];
                        end
                        CMD_TYPEMATIC:
                        begin
                            queue_next = REPLY_ACK[QUEUE_W-1:0];
                            pend_next  = PEND_RATE;
                        end
                        CMD_ENABLE:
                        begin
                            reporting_off_next = 1'b0;
                            queue_next         = REPLY_ACK[QUEUE_W-1:0];
                        end
                        CMD_DISABLE:
                        begin
                            reporting_off_next = 1'b1;
                            queue_next         = REPLY_ACK[QUEUE_W-1:0];
                        end
                        CMD_RESEND:
                        begin
                            queue_next = QUEUE_W'(last_byte_reg);
                        end
                        default:
                        begin
                            if (item.host_byte >= CMD_ACK_LOW)
                            begin
                                queue_next = REPLY_ACK[QUEUE_W-1:0];
                            end
                            else
                            begin
                                result.irq = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ACT_HOST_READ:
            begin
                if (queue_reg[7:0] != 8'd0)
                begin
                    result.read_byte  = queue_reg[7:0];
                    result.read_valid = 1'b1;
                    last_byte_next    = queue_reg[7:0];
                    queue_next        = queue_reg >> 8;
                end
            end
            ACT_TICK:
            begin
                if (repeat_left_reg != '0)
                begin
                    if (LEFT_W'(item.elapsed_ns) >= repeat_left_reg)
                    begin
                        queue_next          = queue_append(queue_reg, WORD_W'(repeat_key_reg));
                        repeat_left_next    = LEFT_W'(repeat_period_reg);
                        result.repeat_fired = 1'b1;
                    end
                    else
                    begin
                        repeat_left_next = repeat_left_reg - LEFT_W'(item.elapsed_ns);
                    end
                end
            end
            ACT_RELEASE_ALL:
            begin
                queue_next     = '0;
                last_byte_next = '0;
                if (repeat_left_reg != '0 && !reporting_off_reg)
                begin
                    queue_next = queue_append('0, break_code(repeat_key_reg, scancode_set));
                    result.irq = 1'b1;
                end
                repeat_left_next = '0;
            end
            default:
            begin
                queue_next = queue_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_reg         <= '0;
            last_byte_reg     <= '0;
            pend_reg          <= PEND_NONE;
            reporting_off_reg <= 1'b0;
            repeat_key_reg    <= '0;
            repeat_left_reg   <= '0;
            repeat_delay_reg  <= DELAY_RESET_NS;
            repeat_period_reg <= PERIOD_RESET_NS;
        end
        else if (step)
        begin
            queue_reg         <= queue_next;
            last_byte_reg     <= last_byte_next;
            pend_reg          <= pend_next;
            reporting_off_reg <= reporting_off_next;
            repeat_key_reg    <= repeat_key_next;
            repeat_left_reg   <= repeat_left_next;
            repeat_delay_reg  <= repeat_delay_next;
            repeat_period_reg <= repeat_period_next;
        end
    end

endmodule

// File: rtl/ps2_keyboard_scancode_device.sv
`timescale 1ns / 1ps
// Channel   Role    Payload
// req       sink    action, key_code, host_byte, elapsed_ns
// rsp       source  read_byte, read_valid, irq, repeat_fired
// apb       slave   scancode_set at byte address 0
//
// Each transaction on req yields one transaction on rsp, through the input
// register and the result register. One transaction per clock is sustained
// while rsp is ready; device state updates as the result register loads.
// req.ready drops only while both registers hold data and rsp is stalled.
// Reset is asynchronous and clears the handshake and all device state.
`include "ps2_keyboard_scancode_device_macros.svh"

module ps2_keyboard_scancode_device (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ps2kb_pkg::PADDR_W-1:0]     paddr,
    input  logic [ps2kb_pkg::PDATA_W-1:0]     pwdata,
    output logic [ps2kb_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    ps2kb_req_if.sink                         req,
    ps2kb_rsp_if.source                       rsp
);
    import ps2kb_pkg::*;

    logic     scancode_set_reg;
    logic     s1_valid_reg;
    item_t    item_reg;
    logic     res_valid_reg;
    result_t  res_reg;
    result_t  core_result;
    logic     advance;
    logic     reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_SCANCODE_SET);
    assign prdata  = (psel && reg_hit) ? PDATA_W'(scancode_set_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scancode_set_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            scancode_set_reg <= pwdata[0];
        end
    end

    assign advance   = !res_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.action     <= req.action;
            item_reg.key_code   <= req.key_code;
            item_reg.host_byte  <= req.host_byte;
            item_reg.elapsed_ns <= req.elapsed_ns;
        end
        if (advance && s1_valid_reg)
        begin
            res_reg <= core_result;
        end
    end

    ps2kb_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance && s1_valid_reg),
        .item         (item_reg),
        .scancode_set (scancode_set_reg),
        .result       (core_result)
    );

    assign rsp.valid        = res_valid_reg;
    assign rsp.read_byte    = res_reg.read_byte;
    assign rsp.read_valid   = res_reg.read_valid;
    assign rsp.irq          = res_reg.irq;
    assign rsp.repeat_fired = res_reg.repeat_fired;

    `KB_ASSERT(a_read_flag_matches_byte, clk, rst_n, res_valid_reg |-> (res_reg.read_valid == (res_reg.read_byte != 8'd0)), "read_valid disagrees with read_byte")
    `KB_ASSERT(a_result_flags_exclusive, clk, rst_n, res_valid_reg |-> !((res_reg.read_valid && (res_reg.irq || res_reg.repeat_fired)) || (res_reg.irq && res_reg.repeat_fired)), "more than one result flag set")
    `KB_ASSERT(a_stage_drains, clk, rst_n, (s1_valid_reg && !res_valid_reg) |=> res_valid_reg, "pending transaction did not reach the result register")
    `KB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!res_valid_reg && !s1_valid_reg), "pipeline not empty after reset")

endmodule
